FILE: design/kps_pkg.sv
// shared types, constants and register codes for the kronecker product stream
// no dependencies
package kps_pkg;

  // sizes of the b store and the a matrix
  localparam int B_DIM_MAX   = 4;
  localparam int A_DIM_MAX   = 1024;
  localparam int STORE_DEPTH = B_DIM_MAX * B_DIM_MAX;
  localparam int BI_W        = (B_DIM_MAX > 1) ? $clog2(B_DIM_MAX) : 1;
  localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // fixed field widths
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int OUT_W  = 12;
  localparam int PROD_W = 64;
  localparam int DIM_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // queue between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_STREAM = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_B    = 2'd0,
    CFG_COLS_B    = 2'd1,
    CFG_SKIP_ZERO = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_WALK = 1'b1
  } back_state_e;

  // dimensions in use after clamping, and the skip mode
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic             skip;
  } cfg_t;

  // one classified item in the queue
  typedef struct packed {
    logic             is_load;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } q_item_t;

endpackage

FILE: design/kronecker_product_stream.sv
// Streaming Kronecker product A (x) B with B held in a 4x4 store of Q16.16
// entries. A load item (cmd 0) takes one queue slot; a stream item (cmd 1)
// walks B column by column, one store entry per cycle, waiting at an entry
// that gives a triplet while the operand stage cannot take it, and yields
// one triplet per cycle when the output is not stalled. An A element holds
// the back end until its walk over up to rows_b*cols_b entries ends, right
// after the last triplet it emits. The pace is set by the single read of
// the B store and the one 32x32 multiplier that every triplet passes
// through. A triplet goes from the store read through the operand stage
// into the output register. A two-entry queue lets input items be taken
// while the back end is still walking. Configuration writes are taken at
// any time and must only be made while the block is idle.
// depends on kps_pkg, kps_front, kps_queue and kps_back
module kronecker_product_stream (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [kps_pkg::IDX_W-1:0]      row_index_i,
  input  logic [kps_pkg::IDX_W-1:0]      col_index_i,
  input  logic signed [kps_pkg::VAL_W-1:0] element_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [kps_pkg::OUT_W-1:0]      out_row_o,
  output logic [kps_pkg::OUT_W-1:0]      out_col_o,
  output logic signed [kps_pkg::PROD_W-1:0] product_value_o,
  output logic                           last_o
);
  import kps_pkg::*;

  cfg_t    cfg;
  q_item_t push_item, pop_item;
  logic    q_push, q_ready, q_pop, q_valid;

  // accept and classify
  kps_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_item_o        (push_item),
    .cfg_o           (cfg)
  );

  // item queue
  kps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  // store, walk and multiply
  kps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_item_i        (pop_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

endmodule

FILE: design/kps_front.sv
// front: configuration registers, item acceptance and classification
// depends on kps_pkg
module kps_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [kps_pkg::IDX_W-1:0]      row_index_i,
  input  logic [kps_pkg::IDX_W-1:0]      col_index_i,
  input  logic [kps_pkg::VAL_W-1:0]      element_value_i,
  input  logic                           q_ready_i,
  output logic                           q_push_o,
  output kps_pkg::q_item_t               q_item_o,
  output kps_pkg::cfg_t                  cfg_o
);
  import kps_pkg::*;

  logic [DIM_W-1:0] rows_q, rows_d;
  logic [DIM_W-1:0] cols_q, cols_d;
  logic             skip_q, skip_d;
  logic [DIM_W-1:0] rows_used, cols_used;
  logic             keep;

  // register writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    skip_d = skip_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ROWS_B:    rows_d = cfg_data_i;
        CFG_COLS_B:    cols_d = cfg_data_i;
        CFG_SKIP_ZERO: skip_d = cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(B_DIM_MAX);
      cols_q <= DIM_W'(B_DIM_MAX);
      skip_q <= 1'b0;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      skip_q <= skip_d;
    end
  end

  // clamp sizes to the store
  assign rows_used = (int'(rows_q) > B_DIM_MAX) ? DIM_W'(B_DIM_MAX) : rows_q;
  assign cols_used = (int'(cols_q) > B_DIM_MAX) ? DIM_W'(B_DIM_MAX) : cols_q;

  assign cfg_o.rows = rows_used;
  assign cfg_o.cols = cols_used;
  assign cfg_o.skip = skip_q;

  // classify: drop loads outside b, and a elements while b has no rows or columns
  always_comb begin
    if (cmd_e'(cmd_i) == CMD_LOAD) begin
      keep = (int'(row_index_i) < int'(rows_used)) && (int'(col_index_i) < int'(cols_used));
    end else begin
      keep = (int'(row_index_i) < A_DIM_MAX) && (int'(col_index_i) < A_DIM_MAX)
          && (rows_used != '0) && (cols_used != '0);
    end
  end

  assign in_ready_o        = q_ready_i;
  assign q_push_o          = in_valid_i && q_ready_i && keep;
  assign q_item_o.is_load  = (cmd_e'(cmd_i) == CMD_LOAD);
  assign q_item_o.row      = row_index_i;
  assign q_item_o.col      = col_index_i;
  assign q_item_o.value    = element_value_i;

endmodule

FILE: design/kps_queue.sv
// short fifo of classified items between front and back
// depends on kps_pkg
module kps_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kps_pkg::q_item_t item_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output kps_pkg::q_item_t item_o
);
  import kps_pkg::*;

  q_item_t          mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (int'(count_q) != QUEUE_DEPTH);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: design/kps_back.sv
// back: b store, walk over b per a element, multiply and output register
// depends on kps_pkg
module kps_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kps_pkg::cfg_t                cfg_i,
  input  logic                         q_valid_i,
  input  kps_pkg::q_item_t             q_item_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kps_pkg::OUT_W-1:0]    out_row_o,
  output logic [kps_pkg::OUT_W-1:0]    out_col_o,
  output logic signed [kps_pkg::PROD_W-1:0] product_value_o,
  output logic                         last_o
);
  import kps_pkg::*;

  back_state_e state_q, state_d;

  logic [VAL_W-1:0]       b_store_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] mask;
  logic [STORE_DEPTH-1:0] rem_q;
  logic [STORE_DEPTH-1:0] cur_bit, rem_left;
  logic [BI_W-1:0]        i_q, j_q;
  logic [OUT_W-1:0]       row_base_q, col_base_q;
  logic [VAL_W-1:0]       a_q;
  logic [SA_W-1:0]        cur_addr, load_addr;
  logic [IDX_W+DIM_W-1:0] row_prod, col_prod;
  logic                   walk, cur_hit, emit, step, start, load;
  logic                   adv_out, s1_free;

  // first pipeline stage
  logic                   s1_valid_q;
  logic [OUT_W-1:0]       s1_row_q, s1_col_q;
  logic signed [VAL_W-1:0] s1_a_q, s1_b_q;
  logic                   s1_last_q;

  // output register
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_row_q, out_col_q;
  logic signed [PROD_W-1:0] out_prod_q, prod;
  logic                   out_last_q;

  // entries that give a triplet for the next a element
  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      mask[k] = ((k / B_DIM_MAX) < int'(cfg_i.rows)) && ((k % B_DIM_MAX) < int'(cfg_i.cols))
             && (!cfg_i.skip || (b_store_q[k] != '0));
    end
  end

  // walk position and handshakes
  assign cur_addr = SA_W'(int'(i_q) * B_DIM_MAX + int'(j_q));
  assign cur_bit  = STORE_DEPTH'(1) << cur_addr;
  assign rem_left = rem_q & ~cur_bit;
  assign cur_hit  = rem_q[cur_addr];
  assign walk     = (state_q == BK_WALK);
  assign adv_out  = !out_valid_q || out_ready_i;
  assign s1_free  = !s1_valid_q || adv_out;
  assign emit     = walk && cur_hit && s1_free;
  assign step     = walk && (!cur_hit || s1_free);
  assign start    = q_pop_o && !q_item_i.is_load && (mask != '0);
  assign load     = q_pop_o && q_item_i.is_load;
  assign load_addr = SA_W'(int'(q_item_i.row[BI_W-1:0]) * B_DIM_MAX
                         + int'(q_item_i.col[BI_W-1:0]));
  assign row_prod = (IDX_W + DIM_W)'(q_item_i.row) * (IDX_W + DIM_W)'(cfg_i.rows);
  assign col_prod = (IDX_W + DIM_W)'(q_item_i.col) * (IDX_W + DIM_W)'(cfg_i.cols);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (start) state_d = BK_WALK;
      BK_WALK: if (step && (rem_left == '0)) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state_q)
      BK_IDLE: q_pop_o = q_valid_i;
      BK_WALK: q_pop_o = 1'b0;
      default: q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // b store, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        b_store_q[k] <= '0;
      end
    end else if (load) begin
      b_store_q[load_addr] <= q_item_i.value;
    end
  end

  // walk counters, column outer and row inner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q   <= '0;
      j_q   <= '0;
      rem_q <= '0;
    end else if (start) begin
      i_q   <= '0;
      j_q   <= '0;
      rem_q <= mask;
    end else if (step) begin
      rem_q <= rem_left;
      if (DIM_W'(i_q) + DIM_W'(1) == cfg_i.rows) begin
        i_q <= '0;
        j_q <= j_q + 1'b1;
      end else begin
        i_q <= i_q + 1'b1;
      end
    end
  end

  // per element operands
  always_ff @(posedge clk_i) begin
    if (start) begin
      row_base_q <= row_prod[OUT_W-1:0];
      col_base_q <= col_prod[OUT_W-1:0];
      a_q        <= q_item_i.value;
    end
  end

  // operand stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_row_q  <= row_base_q + OUT_W'(i_q);
      s1_col_q  <= col_base_q + OUT_W'(j_q);
      s1_a_q    <= a_q;
      s1_b_q    <= b_store_q[cur_addr];
      s1_last_q <= (rem_left == '0);
    end
  end

  // multiply into the output register
  assign prod = s1_a_q * s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      out_row_q  <= s1_row_q;
      out_col_q  <= s1_col_q;
      out_prod_q <= prod;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = out_prod_q;
  assign last_o          = out_last_q;

  // checks
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == BK_IDLE))
    else $error("queue popped during a walk");

  a_walk_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_WALK) |-> (rem_q != '0))
    else $error("walk with no entries left");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> s1_valid_q)
    else $error("operand stage lost an item under stall");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (rem_left == '0)) |=> (state_q == BK_IDLE))
    else $error("walk continued after the last triplet");

endmodule
